// ===== design/fpa_pkg.sv =====
package fpa_pkg;

  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_MIN      = 4'd4,
    KIND_MAX      = 4'd5,
    KIND_INC      = 4'd6,
    KIND_DEC      = 4'd7,
    KIND_FROM_INT = 4'd8,
    KIND_TO_INT   = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // sideband that rides alongside the divider
  typedef struct packed {
    kind_t       kind;
    logic [31:0] simple_res;
    status_t     simple_st;
    logic        less;
    logic        equal;
    logic        greater;
    logic [63:0] prod;
    logic        a_neg;
    logic        a_zero;
    logic        b_zero;
    logic        q_neg;
  } side_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } sat_t;

  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
  localparam logic [31:0] MAX32     = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32     = 32'h8000_0000;

  // apply a sign to a magnitude and clip to the signed 32-bit range
  function automatic sat_t signed_sat(input logic neg, input logic [63:0] mag);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      if (mag > NEG_LIMIT) begin
        s.value = MIN32;
        s.ovf   = 1'b1;
      end else begin
        s.value = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > POS_LIMIT) begin
        s.value = MAX32;
        s.ovf   = 1'b1;
      end else begin
        s.value = mag[31:0];
      end
    end
    return s;
  endfunction

endpackage

// ===== design/fpa_front.sv =====
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int NW        = 41
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  logic [3:0]         kind_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [31:0]        den_o,
  output logic [32+NW-1:0]   acc_o
);

  logic               valid_r;
  side_t              side_r, side_nxt;
  logic [31:0]        den_r, den_nxt;
  logic [32+NW-1:0]   acc_r, acc_nxt;

  logic [32:0]        sum_add, sum_sub, sum_inc, sum_dec;
  logic [31:0]        mag_a, mag_b;
  logic [FRAC_BITS:0] a_top;

  always_comb begin
    sum_add = {a_i[31], a_i} + {b_i[31], b_i};
    sum_sub = {a_i[31], a_i} - {b_i[31], b_i};
    sum_inc = {a_i[31], a_i} + 33'd1;
    sum_dec = {a_i[31], a_i} - 33'd1;
    mag_a   = a_i[31] ? (32'd0 - a_i) : a_i;
    mag_b   = b_i[31] ? (32'd0 - b_i) : b_i;
    a_top   = a_i[31:31-FRAC_BITS];

    side_nxt.kind    = kind_t'(kind_i);
    side_nxt.less    = $signed(a_i) <  $signed(b_i);
    side_nxt.equal   = a_i == b_i;
    side_nxt.greater = $signed(a_i) >  $signed(b_i);
    side_nxt.prod    = 64'($signed(a_i) * $signed(b_i));
    side_nxt.a_neg   = a_i[31];
    side_nxt.a_zero  = a_i == 32'd0;
    side_nxt.b_zero  = b_i == 32'd0;
    side_nxt.q_neg   = a_i[31] ^ b_i[31];

    side_nxt.simple_res = 32'd0;
    side_nxt.simple_st  = ST_OK;
    case (kind_t'(kind_i))
      KIND_ADD: begin
        side_nxt.simple_res = sum_add[31:0];
        if (sum_add[32] != sum_add[31]) side_nxt.simple_st = ST_OVF;
      end
      KIND_SUB: begin
        side_nxt.simple_res = sum_sub[31:0];
        if (sum_sub[32] != sum_sub[31]) side_nxt.simple_st = ST_OVF;
      end
      KIND_INC: begin
        side_nxt.simple_res = sum_inc[31:0];
        if (sum_inc[32] != sum_inc[31]) side_nxt.simple_st = ST_OVF;
      end
      KIND_DEC: begin
        side_nxt.simple_res = sum_dec[31:0];
        if (sum_dec[32] != sum_dec[31]) side_nxt.simple_st = ST_OVF;
      end
      KIND_MIN: side_nxt.simple_res = side_nxt.less ? a_i : b_i;
      KIND_MAX: side_nxt.simple_res = side_nxt.greater ? a_i : b_i;
      KIND_FROM_INT: begin
        if ((&a_top) || !(|a_top)) begin
          side_nxt.simple_res = {a_i[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end else begin
          side_nxt.simple_res = a_i[31] ? MIN32 : MAX32;
          side_nxt.simple_st  = ST_OVF;
        end
      end
      KIND_TO_INT: side_nxt.simple_res = 32'($signed(a_i) >>> FRAC_BITS);
      default: side_nxt.simple_res = 32'd0;
    endcase

    // dividend carries one extra fraction bit for the rounding step
    den_nxt = mag_b;
    acc_nxt = {32'd0, mag_a, {(FRAC_BITS+1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    side_r <= side_nxt;
    den_r  <= den_nxt;
    acc_r  <= acc_nxt;
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign den_o   = den_r;
  assign acc_o   = acc_r;

endmodule

// ===== design/fpa_div_stage.sv =====
module fpa_div_stage import fpa_pkg::*; #(
  parameter int NW    = 41,
  parameter int STEPS = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  side_t            side_i,
  input  logic [31:0]      den_i,
  input  logic [32+NW-1:0] acc_i,
  output logic             valid_o,
  output side_t            side_o,
  output logic [31:0]      den_o,
  output logic [32+NW-1:0] acc_o
);

  logic             valid_r;
  side_t            side_r;
  logic [31:0]      den_r;
  logic [32+NW-1:0] acc_r, acc_nxt;

  logic [31:0]      rem;
  logic [32:0]      rem2;
  logic [NW-1:0]    lo;

  // restoring division, quotient bits shift in where dividend bits leave
  always_comb begin
    rem  = acc_i[32+NW-1:NW];
    lo   = acc_i[NW-1:0];
    rem2 = 33'd0;
    for (int s = 0; s < STEPS; s++) begin
      rem2 = {rem, lo[NW-1]};
      lo   = lo << 1;
      if (rem2 >= {1'b0, den_i}) begin
        rem2  = rem2 - {1'b0, den_i};
        lo[0] = 1'b1;
      end
      rem = rem2[31:0];
    end
    acc_nxt = {rem, lo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    side_r <= side_i;
    den_r  <= den_i;
    acc_r  <= acc_nxt;
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign den_o   = den_r;
  assign acc_o   = acc_r;

endmodule

// ===== design/fpa_back.sv =====
module fpa_back import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int NW        = 41
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  side_t         side_i,
  input  logic [NW-1:0] quo_i,
  output logic          valid_o,
  output logic [31:0]   result_o,
  output logic          less_o,
  output logic          equal_o,
  output logic          greater_o,
  output status_t       status_o
);

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  // rounding stage
  logic          rnd_valid_r;
  side_t         rnd_side_r;
  logic [63:0]   mul_mag_r, mul_mag_nxt;
  logic [NW-1:0] div_q_r, div_q_nxt;
  logic [63:0]   mul_sum;
  logic [NW:0]   q_sum;

  always_comb begin
    mul_sum     = side_i.prod[63] ? (HALF - side_i.prod) : (side_i.prod + HALF);
    mul_mag_nxt = mul_sum >> FRAC_BITS;
    q_sum       = {1'b0, quo_i} + {{NW{1'b0}}, 1'b1};
    div_q_nxt   = q_sum[NW:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_valid_r <= 1'b0;
    end else begin
      rnd_valid_r <= valid_i;
    end
    rnd_side_r <= side_i;
    mul_mag_r  <= mul_mag_nxt;
    div_q_r    <= div_q_nxt;
  end

  // clip and select stage
  logic        out_valid_r;
  logic [31:0] res_r, res_nxt;
  status_t     st_r, st_nxt;
  logic [2:0]  cmp_r;
  sat_t        mul_sat, div_sat;

  always_comb begin
    mul_sat = signed_sat(rnd_side_r.prod[63], mul_mag_r);
    div_sat = signed_sat(rnd_side_r.q_neg, 64'(div_q_r));
    res_nxt = rnd_side_r.simple_res;
    st_nxt  = rnd_side_r.simple_st;
    case (rnd_side_r.kind)
      KIND_MUL: begin
        res_nxt = mul_sat.value;
        st_nxt  = mul_sat.ovf ? ST_OVF : ST_OK;
      end
      KIND_DIV: begin
        if (rnd_side_r.b_zero) begin
          st_nxt = ST_DIV0;
          if (rnd_side_r.a_zero)     res_nxt = 32'd0;
          else if (rnd_side_r.a_neg) res_nxt = MIN32;
          else                       res_nxt = MAX32;
        end else begin
          res_nxt = div_sat.value;
          st_nxt  = div_sat.ovf ? ST_OVF : ST_OK;
        end
      end
      default: begin
        res_nxt = rnd_side_r.simple_res;
        st_nxt  = rnd_side_r.simple_st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rnd_valid_r;
    end
    res_r <= res_nxt;
    st_r  <= st_nxt;
    cmp_r <= {rnd_side_r.less, rnd_side_r.equal, rnd_side_r.greater};
  end

  assign valid_o   = out_valid_r;
  assign result_o  = res_r;
  assign status_o  = st_r;
  assign less_o    = cmp_r[2];
  assign equal_o   = cmp_r[1];
  assign greater_o = cmp_r[0];

endmodule

// ===== design/fixed_point_alu_unit.sv =====
// channel   | ports                                              | direction
// input     | start, busy, in_kind, in_operand_a, in_operand_b   | in (busy out)
// result    | out_valid, out_result, out_less, out_equal,        | out
//           | out_greater, out_status                            |
//
// one beat enters per cycle; every kind runs through the same pipeline, so a
// result leaves through the front register, the divider stages, then the
// rounding and clip stages; the divider, two quotient bits a stage, sets
// the depth
// reset is synchronous, active low, and clears only the valid bits
// the receiver cannot stall, so busy stays low and nothing is ever held back
module fixed_point_alu_unit import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_kind,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_result,
  output logic        out_less,
  output logic        out_equal,
  output logic        out_greater,
  output logic [1:0]  out_status
);

  // dividend is |a| with FRAC_BITS+1 zero bits appended: the extra bit gives
  // twice the quotient, from which rounding half away from zero follows
  localparam int NW   = 33 + FRAC_BITS;
  localparam int NDIV = (NW + 1) / 2;
  localparam int AW   = 32 + NW;

  // taps between divider stages
  logic          valid_p [NDIV+1];
  side_t         side_p  [NDIV+1];
  logic [31:0]   den_p   [NDIV+1];
  logic [AW-1:0] acc_p   [NDIV+1];
  status_t       status_w;

  // never stalls: a beat may arrive every cycle
  assign busy = 1'b0;

  // operand decode, simple kinds, compare flags, multiplier, divider set-up
  fpa_front #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start & ~busy),
    .kind_i  (in_kind),
    .a_i     (in_operand_a),
    .b_i     (in_operand_b),
    .valid_o (valid_p[0]),
    .side_o  (side_p[0]),
    .den_o   (den_p[0]),
    .acc_o   (acc_p[0])
  );

  // divider pipeline, two quotient bits per stage (last one may take one)
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    localparam int STEPS = ((NW - 2*i) < 2) ? (NW - 2*i) : 2;
    fpa_div_stage #(
      .NW    (NW),
      .STEPS (STEPS)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_p[i]),
      .side_i  (side_p[i]),
      .den_i   (den_p[i]),
      .acc_i   (acc_p[i]),
      .valid_o (valid_p[i+1]),
      .side_o  (side_p[i+1]),
      .den_o   (den_p[i+1]),
      .acc_o   (acc_p[i+1])
    );
  end

  // rounding, clipping and the output register
  fpa_back #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (valid_p[NDIV]),
    .side_i    (side_p[NDIV]),
    .quo_i     (acc_p[NDIV][NW-1:0]),
    .valid_o   (out_valid),
    .result_o  (out_result),
    .less_o    (out_less),
    .equal_o   (out_equal),
    .greater_o (out_greater),
    .status_o  (status_w)
  );

  assign out_status = status_w;

endmodule

// ===== design/fpa_checker.sv =====
module fpa_checker #(
  parameter int FRAC_BITS = 8
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_less,
  input logic out_equal,
  input logic out_greater
);

  localparam int LAT = (34 + FRAC_BITS) / 2 + 3;
  localparam int CW  = $clog2(LAT + 2);

  // cycles since reset left, saturating past the pipeline depth
  logic [CW-1:0] run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (run_r <= CW'(LAT)) begin
      run_r <= run_r + CW'(1);
    end
  end

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r > CW'(LAT)) |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result beat does not match accepted beat latency");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_less, out_equal, out_greater}))
    else $error("compare flags not exactly one");

endmodule

bind fixed_point_alu_unit fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_less    (out_less),
  .out_equal   (out_equal),
  .out_greater (out_greater)
);

// ===== tb/fixed_point_alu_unit_test.sv =====
module fixed_point_alu_unit_test;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  // pipeline depth of the unit, from the front register to the output
  localparam int LATENCY = (FRAC + 34) / 2 + 3;

  typedef struct {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [1:0]  st;
  } alu_res_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;   // expected result typed in below
    logic [31:0] value;
    logic [1:0]  st;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_kind = '0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic [31:0] out_result;
  logic        out_less;
  logic        out_equal;
  logic        out_greater;
  logic [1:0]  out_status;

  alu_res_t pending_results[$];
  int       fail_count = 0;

  fixed_point_alu_unit #(.FRAC_BITS(FRAC)) dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_operand_a, .in_operand_b,
    .out_valid, .out_result, .out_less, .out_equal, .out_greater, .out_status
  );

  always #5 clk = ~clk;

  // generous fixed ceiling, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // signed magnitude clip to 32 bits
  function automatic logic [32:0] clip_signed(input bit neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'd0 - mag[31:0]};
    end
    if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

  function automatic alu_res_t compute_alu(input logic [3:0] op, input logic [31:0] a_raw,
                                           input logic [31:0] b_raw);
    alu_res_t r;
    longint a, b, s, p;
    logic [63:0] m, num, den;
    logic [32:0] c;
    a = longint'($signed(a_raw));
    b = longint'($signed(b_raw));
    r.value = '0;
    r.st = ST_OK;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    case (op)
      KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
        case (op)
          KIND_ADD: s = a + b;
          KIND_SUB: s = a - b;
          KIND_INC: s = a + 1;
          default:  s = a - 1;
        endcase
        r.value = s[31:0];
        // wrapped value differs from true sum means overflow
        if (longint'($signed(s[31:0])) != s) r.st = ST_OVF;
      end
      KIND_MUL: begin
        p = a * b;
        m = (p < 0) ? 64'd0 - p : p;
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        c = clip_signed(p < 0, m);
        r.value = c[31:0];
        if (c[32]) r.st = ST_OVF;
      end
      KIND_DIV: begin
        if (b == 0) begin
          r.st = ST_DIV0;
          r.value = (a > 0) ? MAX32 : ((a < 0) ? MIN32 : 32'd0);
        end else begin
          num = ((a < 0) ? 64'd0 - a : a) << FRAC;
          den = (b < 0) ? 64'd0 - b : b;
          // round half away from zero
          c = clip_signed((a < 0) != (b < 0), (2 * num + den) / (2 * den));
          r.value = c[31:0];
          if (c[32]) r.st = ST_OVF;
        end
      end
      KIND_MIN: r.value = (a < b) ? a_raw : b_raw;
      KIND_MAX: r.value = (a > b) ? a_raw : b_raw;
      KIND_FROM_INT: begin
        s = a * (64'sd1 <<< FRAC);
        c = clip_signed(s < 0, (s < 0) ? 64'd0 - s : s);
        r.value = c[31:0];
        if (c[32]) r.st = ST_OVF;
      end
      KIND_TO_INT: r.value = $signed(a_raw) >>> FRAC;
      default: ;
    endcase
    return r;
  endfunction

  // result checker: every strobe beat is matched to the oldest expectation
  always @(posedge clk) begin
    alu_res_t w;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", out_result, 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_result !== w.value) report_mismatch("result", out_result, w.value);
        if (out_less !== w.lt) report_mismatch("less", out_less, w.lt);
        if (out_equal !== w.eq) report_mismatch("equal", out_equal, w.eq);
        if (out_greater !== w.gt) report_mismatch("greater", out_greater, w.gt);
        if (out_status !== w.st) report_mismatch("status", out_status, w.st);
      end
    end
  end

  // drive one beat; the valid stays up across back-to-back beats
  task automatic send_op(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                         input int gap);
    alu_res_t want;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = compute_alu(op, a, b);
    pending_results.push_back(want);
  endtask

  // wait until every expected beat has drained
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 3) - 1;
      3: return $signed($urandom_range(0, 2000)) - 1000;        // small values
      4: return ($signed($urandom_range(0, 200)) - 100) <<< FRAC; // whole numbers
      5: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  vec_t directed_vectors[] = '{
    '{KIND_ADD, 32'h7FFF_FFFF, 32'd1, 1, 32'h8000_0000, ST_OVF},
    '{KIND_SUB, 32'h8000_0000, 32'd1, 1, 32'h7FFF_FFFF, ST_OVF},
    '{KIND_INC, 32'h7FFF_FFFF, 32'd0, 1, 32'h8000_0000, ST_OVF},
    '{KIND_DEC, 32'h8000_0000, 32'd0, 1, 32'h7FFF_FFFF, ST_OVF},
    '{KIND_DIV, 32'd5, 32'd0, 1, 32'h7FFF_FFFF, ST_DIV0},
    '{KIND_DIV, 32'hFFFF_FFFB, 32'd0, 1, 32'h8000_0000, ST_DIV0},
    '{KIND_DIV, 32'd0, 32'd0, 1, 32'd0, ST_DIV0},
    '{KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, ST_OVF},
    '{KIND_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000, ST_OVF},
    '{KIND_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},
    '{KIND_MUL, 32'd1, 32'd128, 0, 0, 0},             // half step, rounds away
    '{KIND_MUL, 32'hFFFF_FFFF, 32'd128, 0, 0, 0},
    '{KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0},
    '{KIND_DIV, 32'd1, 32'd512, 0, 0, 0},             // exact half
    '{KIND_MIN, 32'd7, 32'd7, 0, 0, 0},
    '{KIND_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0},
    '{KIND_FROM_INT, 32'h7FFF_FFFF, 32'd0, 1, 32'h7FFF_FFFF, ST_OVF},
    '{KIND_FROM_INT, 32'h8000_0000, 32'd0, 1, 32'h8000_0000, ST_OVF},
    '{KIND_FROM_INT, 32'hFF80_0000, 32'd0, 1, 32'h8000_0000, ST_OK},
    '{KIND_TO_INT, 32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF, ST_OK},
    '{KIND_TO_INT, 32'h7FFF_FFFF, 32'd0, 1, 32'h007F_FFFF, ST_OK},
    '{4'd10, 32'd3, 32'd4, 0, 0, 0},                 // unused kinds give zero
    '{4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0}
  };

  initial begin
    alu_res_t typed;
    int gap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, typed rows checked against the predictor too
    foreach (directed_vectors[i]) begin
      if (directed_vectors[i].typed) begin
        typed = compute_alu(directed_vectors[i].op, directed_vectors[i].a,
                            directed_vectors[i].b);
        if (typed.value !== directed_vectors[i].value || typed.st !== directed_vectors[i].st)
          report_mismatch("typed row", typed.value, directed_vectors[i].value);
      end
      send_op(directed_vectors[i].op, directed_vectors[i].a, directed_vectors[i].b, 0);
    end
    // sender holds off until the pipe has emptied
    drain_results();

    for (int n = 0; n < 1750; n++) begin
      // a random idle gap, possibly none, ahead of every beat
      gap = $urandom_range(0, 3);
      send_op($urandom_range(0, 15) < 14 ? $urandom_range(0, 9) : $urandom_range(10, 15),
              pick_operand(), pick_operand(), gap);
      if (n == 900) drain_results();
    end
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
